[hw/rtl/raf_pkg.sv]
// ----------------------------------------------------------------------------
// raf_pkg
// Types, format codes and character helpers for the radix ASCII formatter.
// ----------------------------------------------------------------------------
package raf_pkg;

    localparam int VALUE_BITS = 16;
    localparam int CHAR_BITS  = 7;
    localparam int COUNT_BITS = 3;
    localparam int DIGIT_BITS = 4;
    localparam int MAX_DIGITS = 6;

    localparam logic [2:0] OP_SDEC   = 3'd0;
    localparam logic [2:0] OP_UDEC   = 3'd1;
    localparam logic [2:0] OP_OCT    = 3'd2;
    localparam logic [2:0] OP_HEXLO  = 3'd3;
    localparam logic [2:0] OP_HEXUP  = 3'd4;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_LO_A  = 7'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_UP_A  = 7'h41;

    // q = (v * DIV10_MUL) >> DIV10_SHIFT is exact for v < 2^16
    localparam logic [31:0] DIV10_MUL   = 32'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef struct packed {
        logic [2:0]            op;
        logic [VALUE_BITS-1:0] value;
    } fmt_in_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0]  ascii_char;
        logic                  last;
        logic [COUNT_BITS-1:0] char_count;
    } fmt_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } raf_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_sign;
        logic emit_digit;
    } raf_cmd_t;

    typedef struct packed {
        logic op_ok;
        logic conv_done;
        logic neg;
        logic last_digit;
    } raf_status_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(
        input logic [DIGIT_BITS-1:0] d,
        input logic                  upper
    );
        logic [CHAR_BITS-1:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end
        else if (upper)
        begin
            c = CHAR_UP_A + CHAR_BITS'(d - 4'd10);
        end
        else
        begin
            c = CHAR_LO_A + CHAR_BITS'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

[hw/rtl/raf_ctrl.sv]
// ----------------------------------------------------------------------------
// raf_ctrl
// Sequencer: load, digit extraction, sign and digit output.
// ----------------------------------------------------------------------------
module raf_ctrl
    import raf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  raf_status_t status,
    output logic        busy,
    output raf_cmd_t    cmd
);

    raf_state_t state_reg;
    raf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && status.op_ok)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (status.conv_done)
                begin
                    state_next = status.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                if (status.last_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start && status.op_ok;
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
            end
            ST_DIGIT:
            begin
                cmd.emit_digit = 1'b1;
            end
        endcase
    end

endmodule

[hw/rtl/raf_dp.sv]
// ----------------------------------------------------------------------------
// raf_dp
// Datapath: magnitude register, one digit per step, digit stack, output stage.
// ----------------------------------------------------------------------------
module raf_dp
    import raf_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  fmt_in_t     cmd_in,
    input  raf_cmd_t    cmd,
    output raf_status_t status,
    output logic        strobe,
    output fmt_out_t    result
);

    localparam int MW = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
    localparam bit SIGN_VISIBLE = (VALUE_WIDTH <= VALUE_BITS);

    logic [MW-1:0]         mag_reg;
    logic [2:0]            op_reg;
    logic                  neg_reg;
    logic [DIGIT_BITS-1:0] stack_reg [MAX_DIGITS];
    logic [COUNT_BITS-1:0] nd_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic                  strobe_reg;
    logic                  strobe_next;
    fmt_out_t              out_reg;
    fmt_out_t              out_next;

    logic [MW-1:0]         v_in;
    logic                  neg_in;
    logic [MW-1:0]         mag_in;
    logic [VALUE_BITS-1:0] mag16;
    logic [31:0]           prod;
    logic [VALUE_BITS-1:0] q10;
    logic [VALUE_BITS-1:0] rem10;
    logic [VALUE_BITS-1:0] q_sel;
    logic [DIGIT_BITS-1:0] d_sel;

    assign v_in   = cmd_in.value[MW-1:0];
    assign neg_in = SIGN_VISIBLE && (cmd_in.op == OP_SDEC) && v_in[MW-1];
    assign mag_in = neg_in ? (~v_in + MW'(1)) : v_in;

    assign mag16 = VALUE_BITS'(mag_reg);
    assign prod  = 32'(mag16) * DIV10_MUL;
    assign q10   = VALUE_BITS'(prod >> DIV10_SHIFT);
    assign rem10 = mag16 - VALUE_BITS'(q10 * 16'd10);

    always_comb
    begin
        unique case (op_reg)
            OP_SDEC, OP_UDEC:
            begin
                q_sel = q10;
                d_sel = rem10[DIGIT_BITS-1:0];
            end
            OP_OCT:
            begin
                q_sel = mag16 >> 3;
                d_sel = {1'b0, mag16[2:0]};
            end
            default:
            begin
                q_sel = mag16 >> 4;
                d_sel = mag16[3:0];
            end
        endcase
    end

    assign status.op_ok      = (cmd_in.op == OP_SDEC) || (cmd_in.op == OP_UDEC) ||
                               (cmd_in.op == OP_OCT) || (cmd_in.op == OP_HEXLO) ||
                               (cmd_in.op == OP_HEXUP);
    assign status.conv_done  = (q_sel == '0);
    assign status.neg        = neg_reg;
    assign status.last_digit = (nd_reg == COUNT_BITS'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg   <= mag_in;
            op_reg    <= cmd_in.op;
            neg_reg   <= neg_in;
            nd_reg    <= '0;
            total_reg <= COUNT_BITS'(neg_in);
        end
        else if (cmd.step)
        begin
            mag_reg      <= MW'(q_sel);
            stack_reg[0] <= d_sel;
            for (int i = 1; i < MAX_DIGITS; i++)
            begin
                stack_reg[i] <= stack_reg[i-1];
            end
            nd_reg    <= nd_reg + COUNT_BITS'(1);
            total_reg <= total_reg + COUNT_BITS'(1);
        end
        else if (cmd.emit_digit)
        begin
            for (int i = 0; i < MAX_DIGITS - 1; i++)
            begin
                stack_reg[i] <= stack_reg[i+1];
            end
            nd_reg <= nd_reg - COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        strobe_next = cmd.emit_sign || cmd.emit_digit;
        out_next    = '0;
        if (cmd.emit_sign)
        begin
            out_next.ascii_char = CHAR_MINUS;
        end
        else
        begin
            out_next.ascii_char = digit_char(stack_reg[0], op_reg == OP_HEXUP);
            out_next.last       = status.last_digit;
            out_next.char_count = status.last_digit ? total_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (strobe_next)
        begin
            out_reg <= out_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = out_reg;

endmodule

[hw/rtl/radix_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// radix_ascii_formatter
// The first character, a minus sign or the top digit, is registered after digit extraction.
// Throughput: digit extraction first, then one character per cycle;
//   the single shared divide-by-radix step sets the extraction length.
// Busy drops as the last character loads.
// Unused format codes start no work and give no characters.
// Reset clears the sequencer and the output strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module radix_ascii_formatter
    import raf_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  fmt_in_t  cmd,
    output logic     busy,
    output logic     strobe,
    output fmt_out_t result
);

    raf_cmd_t    ctl;
    raf_status_t status;

    raf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (ctl)
    );

    raf_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_in (cmd),
        .cmd    (ctl),
        .status (status),
        .strobe (strobe),
        .result (result)
    );

endmodule

[hw/rtl/raf_checker.sv]
// ----------------------------------------------------------------------------
// raf_checker
// Port-level checks for the radix ASCII formatter, bound to the top level.
// ----------------------------------------------------------------------------
module raf_checker
    import raf_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input fmt_in_t  cmd,
    input logic     busy,
    input logic     strobe,
    input fmt_out_t result
);

    logic op_ok;
    assign op_ok = (cmd.op == OP_SDEC) || (cmd.op == OP_UDEC) || (cmd.op == OP_OCT) ||
                   (cmd.op == OP_HEXLO) || (cmd.op == OP_HEXUP);

    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |-> result.char_count != 3'd0)
        else $error("last transfer without a character count");

    a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> result.char_count == 3'd0)
        else $error("count shown before the last transfer");

    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe)
        else $error("gap inside a conversion");

    a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !op_ok |=> !busy && !strobe)
        else $error("unused format code started work");

    a_good_op: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op_ok |=> busy)
        else $error("accepted item did not start");

endmodule

bind radix_ascii_formatter raf_checker u_raf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
